// ===== hw/rtl/second_chance_frame_replacer_defines.svh =====
// ----------------------------------------------------------------------------
// second chance frame replacer assertion macros
// shared property wrappers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SECOND_CHANCE_FRAME_REPLACER_DEFINES_SVH
`define SECOND_CHANCE_FRAME_REPLACER_DEFINES_SVH

// invariant that holds at every clock edge out of reset
`define SCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked in the same cycle
`define SCFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/scfr_pkg.sv =====
// ----------------------------------------------------------------------------
// scfr_pkg
// shared sizes, codes and memory entry types of the frame replacer
// ----------------------------------------------------------------------------
`default_nettype none

package scfr_pkg;

  // pool size and derived widths
  localparam int NumFrames = 64;
  localparam int FrameW    = $clog2(NumFrames);
  localparam int CountW    = $clog2(NumFrames + 1);

  typedef logic [FrameW-1:0] frame_t;
  typedef logic [CountW-1:0] count_t;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_TOUCH  = 2'd2;
  localparam logic [1:0] REQ_EVICT  = 2'd3;

  // page kinds
  localparam logic [1:0] KIND_BINARY = 2'd0;
  localparam logic [1:0] KIND_FILE   = 2'd1;
  localparam logic [1:0] KIND_ANON   = 2'd2;

  // writeback actions
  localparam logic [1:0] ACT_DROP = 2'd0;
  localparam logic [1:0] ACT_FILE = 2'd1;
  localparam logic [1:0] ACT_SWAP = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_PRESENT = 2'd1;
  localparam logic [1:0] STAT_ABSENT  = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  // ring links of one frame
  typedef struct packed {
    frame_t next_frame;
    frame_t prev_frame;
  } lnk_entry_t;

  // per-frame attributes
  typedef struct packed {
    logic       accessed;
    logic       dirty;
    logic [1:0] kind;
  } atr_entry_t;

  // link memory write command, one enable per field
  typedef struct packed {
    logic       we_next;
    logic       we_prev;
    frame_t     addr;
    lnk_entry_t data;
  } lnk_wr_t;

  // attribute memory write command, one enable per field
  typedef struct packed {
    logic       we_acc;
    logic       we_dirty;
    logic       we_kind;
    frame_t     addr;
    atr_entry_t data;
  } atr_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scfr_if.sv =====
// ----------------------------------------------------------------------------
// scfr request and response channels
// valid/ready channels carrying the replacer's request and result payloads
// ----------------------------------------------------------------------------
`default_nettype none

interface scfr_req_if import scfr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  frame_t     frame_number;
  logic [1:0] page_kind;
  logic       is_write;

  modport source (output valid, output req_type, output frame_number,
                  output page_kind, output is_write, input ready);
  modport sink   (input valid, input req_type, input frame_number,
                  input page_kind, input is_write, output ready);
endinterface

interface scfr_rsp_if import scfr_pkg::*; ();
  logic       valid;
  logic       ready;
  frame_t     victim_frame;
  logic [1:0] writeback_action;
  logic [1:0] victim_kind;
  logic [1:0] status;

  modport source (output valid, output victim_frame, output writeback_action,
                  output victim_kind, output status, input ready);
  modport sink   (input valid, input victim_frame, input writeback_action,
                  input victim_kind, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scfr_store.sv =====
// ----------------------------------------------------------------------------
// scfr_store
// link and attribute memories, field-masked writes, registered reads
// ----------------------------------------------------------------------------
`default_nettype none

module scfr_store import scfr_pkg::*; (
  input  wire logic       clk_i,
  input  wire lnk_wr_t    lnk_wr_i,
  input  wire atr_wr_t    atr_wr_i,
  input  wire logic       rd_en_i,
  input  wire frame_t     rd_addr_i,
  output lnk_entry_t      lnk_rd_o,
  output atr_entry_t      atr_rd_o
);

  lnk_entry_t lnk_mem [NumFrames];
  atr_entry_t atr_mem [NumFrames];
  lnk_entry_t lnk_rd_q;
  atr_entry_t atr_rd_q;

  // link memory, read returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (lnk_wr_i.we_next) begin
      lnk_mem[lnk_wr_i.addr].next_frame <= lnk_wr_i.data.next_frame;
    end
    if (lnk_wr_i.we_prev) begin
      lnk_mem[lnk_wr_i.addr].prev_frame <= lnk_wr_i.data.prev_frame;
    end
    if (rd_en_i) begin
      lnk_rd_q <= lnk_mem[rd_addr_i];
    end
  end

  // attribute memory
  always_ff @(posedge clk_i) begin
    if (atr_wr_i.we_acc) begin
      atr_mem[atr_wr_i.addr].accessed <= atr_wr_i.data.accessed;
    end
    if (atr_wr_i.we_dirty) begin
      atr_mem[atr_wr_i.addr].dirty <= atr_wr_i.data.dirty;
    end
    if (atr_wr_i.we_kind) begin
      atr_mem[atr_wr_i.addr].kind <= atr_wr_i.data.kind;
    end
    if (rd_en_i) begin
      atr_rd_q <= atr_mem[rd_addr_i];
    end
  end

  assign lnk_rd_o = lnk_rd_q;
  assign atr_rd_o = atr_rd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/second_chance_frame_replacer.sv =====
// ----------------------------------------------------------------------------
// second_chance_frame_replacer
// clock (second chance) replacement over a doubly linked ring of frames
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives exactly one response. The
// ring links and frame attributes live in two single-write-port memories with
// registered reads; present bits, head, tail and the frame count are flops, so
// no clearing pass is needed after reset. Touch and rejected requests go
// straight to the response state, as does an insert into an empty pool; other
// inserts first link the frame behind the tail. Free unlinks the frame on the
// predecessor side, then the successor side. Evict walks from the head past
// accessed frames and unlinks the first unaccessed one the same way; the walk
// reads one frame per cycle through the shared read port. The next request is
// taken in the cycle after the response is loaded, and the response may wait
// for the output register to be free. A new request is taken while the
// previous response still waits in the output register.
`default_nettype none
`include "second_chance_frame_replacer_defines.svh"

module second_chance_frame_replacer import scfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  scfr_req_if.sink  req_i,
  scfr_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_TAIL,
    ST_WALK,
    ST_DET_NEXT,
    ST_DET_PREV,
    ST_RESP
  } state_e;

  state_e                 state_q;
  frame_t                 head_q, tail_q, f_q, cur_q;
  count_t                 count_q;
  logic [NumFrames-1:0]   present_q;
  logic                   fwd_q;
  frame_t                 res_victim_q;
  logic [1:0]             res_action_q, res_kind_q, res_status_q;
  logic                   out_valid_q;
  frame_t                 out_victim_q;
  logic [1:0]             out_action_q, out_kind_q, out_status_q;

  lnk_wr_t    lnk_wr;
  atr_wr_t    atr_wr;
  logic       rd_en;
  frame_t     rd_addr;
  lnk_entry_t lnk_rd;
  atr_entry_t atr_rd;

  logic       in_acc;
  logic       present_in;
  logic [1:0] kind_sat;
  logic       walk_acc;
  frame_t     nxt_cur;
  logic       needs_wb;
  logic [1:0] evict_action, evict_kind;

  scfr_store u_store (
    .clk_i     (clk_i),
    .lnk_wr_i  (lnk_wr),
    .atr_wr_i  (atr_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .lnk_rd_o  (lnk_rd),
    .atr_rd_o  (atr_rd)
  );

  // request handshake and decode
  assign req_i.ready = (state_q == ST_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign present_in  = present_q[req_i.frame_number];
  assign kind_sat    = (req_i.page_kind > KIND_ANON) ? KIND_ANON : req_i.page_kind;

  // walk step: accessed bit of the current frame, unless just cleared in place
  assign walk_acc = atr_rd.accessed && !fwd_q;
  assign nxt_cur  = (cur_q == tail_q) ? head_q : lnk_rd.next_frame;

  // eviction outcome of the frame under the walk pointer
  assign needs_wb     = atr_rd.dirty || (atr_rd.kind == KIND_ANON);
  assign evict_action = !needs_wb ? ACT_DROP :
                        (atr_rd.kind == KIND_FILE) ? ACT_FILE : ACT_SWAP;
  assign evict_kind   = (needs_wb && atr_rd.kind != KIND_FILE) ? KIND_ANON : atr_rd.kind;

  // memory read and write commands
  always_comb begin
    lnk_wr  = '0;
    atr_wr  = '0;
    rd_en   = 1'b0;
    rd_addr = head_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (req_i.req_type)
            REQ_INSERT: begin
              if (!present_in) begin
                lnk_wr.we_next         = 1'b1;
                lnk_wr.we_prev         = 1'b1;
                lnk_wr.addr            = req_i.frame_number;
                lnk_wr.data.next_frame = req_i.frame_number;
                lnk_wr.data.prev_frame = (count_q == '0) ? req_i.frame_number : tail_q;
                atr_wr.we_acc          = 1'b1;
                atr_wr.we_dirty        = 1'b1;
                atr_wr.we_kind         = 1'b1;
                atr_wr.addr            = req_i.frame_number;
                atr_wr.data.kind       = kind_sat;
              end
            end
            REQ_FREE: begin
              if (present_in) begin
                rd_en   = 1'b1;
                rd_addr = req_i.frame_number;
              end
            end
            REQ_TOUCH: begin
              if (present_in) begin
                atr_wr.we_acc        = 1'b1;
                atr_wr.we_dirty      = req_i.is_write;
                atr_wr.addr          = req_i.frame_number;
                atr_wr.data.accessed = 1'b1;
                atr_wr.data.dirty    = 1'b1;
              end
            end
            REQ_EVICT: begin
              if (count_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = head_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INS_TAIL: begin
        lnk_wr.we_next         = 1'b1;
        lnk_wr.addr            = tail_q;
        lnk_wr.data.next_frame = f_q;
      end
      ST_WALK: begin
        if (walk_acc) begin
          atr_wr.we_acc = 1'b1;
          atr_wr.addr   = cur_q;
          rd_en         = 1'b1;
          rd_addr       = nxt_cur;
        end
      end
      ST_DET_NEXT: begin
        if (count_q > count_t'(1) && f_q != head_q) begin
          lnk_wr.we_next         = 1'b1;
          lnk_wr.addr            = lnk_rd.prev_frame;
          lnk_wr.data.next_frame = lnk_rd.next_frame;
        end
      end
      ST_DET_PREV: begin
        if (count_q > count_t'(1) && f_q != tail_q) begin
          lnk_wr.we_prev         = 1'b1;
          lnk_wr.addr            = lnk_rd.next_frame;
          lnk_wr.data.prev_frame = lnk_rd.prev_frame;
        end
      end
      default: ;
    endcase
  end

  // sequencer, ring bookkeeping and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      present_q    <= '0;
      f_q          <= '0;
      cur_q        <= '0;
      fwd_q        <= 1'b0;
      res_victim_q <= '0;
      res_action_q <= ACT_DROP;
      res_kind_q   <= KIND_BINARY;
      res_status_q <= STAT_OK;
      out_valid_q  <= 1'b0;
      out_victim_q <= '0;
      out_action_q <= ACT_DROP;
      out_kind_q   <= KIND_BINARY;
      out_status_q <= STAT_OK;
    end else begin
      if (out_valid_q && rsp_o.ready && state_q != ST_RESP) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            f_q          <= req_i.frame_number;
            res_victim_q <= req_i.frame_number;
            res_action_q <= ACT_DROP;
            res_kind_q   <= KIND_BINARY;
            res_status_q <= STAT_OK;
            state_q      <= ST_RESP;
            case (req_i.req_type)
              REQ_INSERT: begin
                if (present_in) begin
                  res_status_q <= STAT_PRESENT;
                end else if (count_q == '0) begin
                  present_q[req_i.frame_number] <= 1'b1;
                  head_q  <= req_i.frame_number;
                  tail_q  <= req_i.frame_number;
                  count_q <= count_t'(1);
                end else begin
                  state_q <= ST_INS_TAIL;
                end
              end
              REQ_FREE: begin
                if (!present_in) begin
                  res_status_q <= STAT_ABSENT;
                end else begin
                  state_q <= ST_DET_NEXT;
                end
              end
              REQ_TOUCH: begin
                if (!present_in) begin
                  res_status_q <= STAT_ABSENT;
                end
              end
              REQ_EVICT: begin
                if (count_q == '0) begin
                  res_status_q <= STAT_EMPTY;
                end else begin
                  cur_q   <= head_q;
                  fwd_q   <= 1'b0;
                  state_q <= ST_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        // link the new frame behind the old tail
        ST_INS_TAIL: begin
          present_q[f_q] <= 1'b1;
          tail_q         <= f_q;
          count_q        <= count_q + count_t'(1);
          state_q        <= ST_RESP;
        end
        // pass over accessed frames, stop at the first unaccessed one
        ST_WALK: begin
          if (walk_acc) begin
            cur_q <= nxt_cur;
            fwd_q <= (nxt_cur == cur_q);
          end else begin
            f_q          <= cur_q;
            res_victim_q <= cur_q;
            res_action_q <= evict_action;
            res_kind_q   <= evict_kind;
            state_q      <= ST_DET_NEXT;
          end
        end
        // unlink: predecessor side and head
        ST_DET_NEXT: begin
          if (count_q <= count_t'(1)) begin
            head_q <= '0;
            tail_q <= '0;
          end else if (f_q == head_q) begin
            head_q <= lnk_rd.next_frame;
          end
          state_q <= ST_DET_PREV;
        end
        // unlink: successor side and tail
        ST_DET_PREV: begin
          if (count_q > count_t'(1) && f_q == tail_q) begin
            tail_q <= lnk_rd.prev_frame;
          end
          present_q[f_q] <= 1'b0;
          count_q        <= count_q - count_t'(1);
          state_q        <= ST_RESP;
        end
        // hand the result to the output register once it is free
        ST_RESP: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_victim_q <= res_victim_q;
            out_action_q <= res_action_q;
            out_kind_q   <= res_kind_q;
            out_status_q <= res_status_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // response channel
  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.victim_frame     = out_victim_q;
  assign rsp_o.writeback_action = out_action_q;
  assign rsp_o.victim_kind      = out_kind_q;
  assign rsp_o.status           = out_status_q;

  // ring consistency checks
  `SCFR_ASSERT(a_count_matches_present, $countones(present_q) == count_q, "count mismatch")
  `SCFR_ASSERT(a_count_in_range, count_q <= count_t'(NumFrames), "count overflow")
  `SCFR_ASSERT_IMPL(a_head_present, state_q == ST_IDLE && count_q != '0, present_q[head_q], "head absent")
  `SCFR_ASSERT_IMPL(a_tail_present, state_q == ST_IDLE && count_q != '0, present_q[tail_q], "tail absent")
  `SCFR_ASSERT_IMPL(a_walk_on_ring, state_q == ST_WALK, present_q[cur_q], "walk left the ring")

endmodule

`default_nettype wire
